[sv/ipv4dq_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types and character constants for the dotted-quad address checker.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

   // Character codes and limits
   localparam logic [7:0] DOT_CHAR       = 8'h2E;
   localparam logic [7:0] ZERO_CHAR      = 8'h30;
   localparam logic [7:0] NINE_CHAR      = 8'h39;
   localparam logic [7:0] GROUP_MAX      = 8'd255;
   localparam logic [7:0] LOOPBACK_GROUP = 8'd127;
   localparam logic [3:0] RADIX          = 4'd10;
   localparam logic [1:0] LAST_DOT       = 2'd3;

   // Width of the octet multiply-add before the range check
   localparam int unsigned WIDE_W = 12;

   // Scan state carried from one character to the next
   typedef struct packed {
      logic [7:0] octet_value;
      logic [1:0] dot_count;
      logic       digit_seen;
      logic       any_nonzero;
      logic [7:0] first_group;
      logic       failed;
   } scan_state_type;

endpackage

[sv/ipv4dq_step.sv]
// ----------------------------------------------------------------------------
// ipv4dq_step
// Per-character update of the scan state and the verdict on the last beat.
// ----------------------------------------------------------------------------
module ipv4dq_step (
   input  ipv4dq_pkg::scan_state_type cur_state,
   input  logic [7:0]                 char_code,
   input  logic                       is_last,
   input  logic                       no_char,
   output ipv4dq_pkg::scan_state_type nxt_state,
   output logic                       emit,
   output logic                       usable
);

   ipv4dq_pkg::scan_state_type upd;
   logic [ipv4dq_pkg::WIDE_W-1:0] digit_val;
   logic [ipv4dq_pkg::WIDE_W-1:0] wide_val;
   logic                          is_dot;
   logic                          is_digit;

   // Decode the character and form octet * 10 + digit
   always_comb begin
      is_dot    = (char_code == ipv4dq_pkg::DOT_CHAR);
      is_digit  = (char_code >= ipv4dq_pkg::ZERO_CHAR) &&
                  (char_code <= ipv4dq_pkg::NINE_CHAR);
      digit_val = ipv4dq_pkg::WIDE_W'(char_code - ipv4dq_pkg::ZERO_CHAR);
      wide_val  = ipv4dq_pkg::WIDE_W'(cur_state.octet_value) *
                  ipv4dq_pkg::WIDE_W'(ipv4dq_pkg::RADIX) + digit_val;
   end

   // Take the character in; once failed, ignore everything until the end
   always_comb begin
      upd = cur_state;
      if (!no_char && !cur_state.failed) begin
         if (is_dot) begin
            if (!cur_state.digit_seen || cur_state.dot_count == ipv4dq_pkg::LAST_DOT) begin
               upd.failed = 1'b1;
            end else begin
               if (cur_state.dot_count == 2'd0) begin
                  upd.first_group = cur_state.octet_value;
               end
               if (cur_state.octet_value != 8'd0) begin
                  upd.any_nonzero = 1'b1;
               end
               upd.dot_count   = cur_state.dot_count + 2'd1;
               upd.octet_value = 8'd0;
               upd.digit_seen  = 1'b0;
            end
         end else if (is_digit) begin
            upd.digit_seen = 1'b1;
            if (wide_val > ipv4dq_pkg::WIDE_W'(ipv4dq_pkg::GROUP_MAX)) begin
               upd.failed = 1'b1;
            end else begin
               upd.octet_value = wide_val[7:0];
            end
         end else begin
            upd.failed = 1'b1;
         end
      end
   end

   // Judge the string and clear the state on the last beat
   always_comb begin
      usable = !upd.failed && upd.digit_seen &&
               (upd.dot_count == ipv4dq_pkg::LAST_DOT) &&
               (upd.any_nonzero || (upd.octet_value != 8'd0)) &&
               (upd.first_group != ipv4dq_pkg::LOOPBACK_GROUP);
      emit      = is_last;
      nxt_state = is_last ? '0 : upd;
   end

endmodule

[sv/ipv4_dotted_quad_checker.sv]
// A last beat is taken into the input register and then, once the result register
// can take it, into the result register, from which its result is read.
// Throughput: one character beat per cycle while no stalled result holds req_stall high.
// A stalled result holds in the output register while the input register keeps
// one more beat; beyond that req_stall rises.
// Reset (synchronous, active high) empties both registers and clears the scan state.
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Checks a dotted-decimal IPv4 address streamed one character per beat.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   input  logic       req_no_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_usable
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_char_ff;
   logic                       in_last_ff;
   logic                       in_nochar_ff;
   ipv4dq_pkg::scan_state_type state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_usable_ff, rsp_usable_in;

   ipv4dq_pkg::scan_state_type step_state;
   logic                       step_emit;
   logic                       step_usable;
   logic                       advance;
   logic                       take_req;

   // Per-character update logic
   ipv4dq_step u_step (
      .cur_state (state_ff),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .no_char   (in_nochar_ff),
      .nxt_state (step_state),
      .emit      (step_emit),
      .usable    (step_usable)
   );

   // Advance the input beat whenever the result register can take it
   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      req_stall = in_valid_ff && !advance;
      take_req  = req_valid && !req_stall;
   end

   // Next values of the input, state and result registers
   always_comb begin
      in_valid_in   = req_stall ? in_valid_ff : req_valid;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_usable_in = rsp_usable_ff;
      if (advance) begin
         rsp_valid_in  = in_valid_ff && step_emit;
         rsp_usable_in = step_usable;
         if (in_valid_ff) begin
            state_in = step_state;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff   <= req_char_code;
         in_last_ff   <= req_is_last;
         in_nochar_ff <= req_no_char;
      end
      rsp_usable_ff <= rsp_usable_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_usable = rsp_usable_ff;

`ifndef SYNTHESIS
   // The last beat of a string leaves the scan state at reset
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_last_ff) |=> (state_ff == '0))
      else $error("scan state not cleared after last beat");

   // Input stalls only behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && in_valid_ff))
      else $error("input stalled without a blocked result");

   // Failure stays set until the string ends
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.failed && !(in_valid_ff && advance && in_last_ff)) |=> state_ff.failed)
      else $error("failure flag dropped before end of string");
`endif

endmodule

[tb/ipv4_dotted_quad_checker_test.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker_test
// Streams address text one character per beat into the dotted-quad checker
// and compares every usable bit with an in-bench scan model, or with the table on
// typed rows. A short table of hand-picked beats comes first, then random addresses
// (mostly well formed, some broken) under changing sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_checker_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned PHASE_COUNT  = 4;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned TAIL_CYCLES  = 8;

   // One row of the directed table; usable is used only when typed is set
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
      logic       typed;
      logic       usable;
   } beat_row_type;

   localparam int unsigned DIRECTED_COUNT = 25;
   localparam beat_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // end-only beat right after reset: empty string
      '{8'h00,                1'b1, 1'b1, 1'b1, 1'b0},
      // 1.2.3.4 with an ignored empty beat inside
      '{"1",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"2",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF,                1'b0, 1'b1, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"3",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"4",                  1'b1, 1'b0, 1'b0, 1'b0},
      // all groups zero
      '{"0",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"0",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"0",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{ipv4dq_pkg::DOT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{"0",                  1'b1, 1'b0, 1'b1, 1'b0},
      // lone dot: empty group
      '{ipv4dq_pkg::DOT_CHAR, 1'b1, 1'b0, 1'b1, 1'b0},
      // byte extremes on the last beat
      '{8'hFF,                1'b1, 1'b0, 1'b1, 1'b0},
      '{8'h00,                1'b1, 1'b0, 1'b1, 1'b0},
      // group above 255
      '{"2",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{"5",                  1'b0, 1'b0, 1'b0, 1'b0},
      '{"6",                  1'b1, 1'b0, 1'b1, 1'b0},
      // neighbors of the digit range
      '{"/",                  1'b1, 1'b0, 1'b1, 1'b0},
      '{":",                  1'b1, 1'b0, 1'b1, 1'b0},
      // lone digit: too few groups
      '{"7",                  1'b1, 1'b0, 1'b1, 1'b0}
   };

   localparam int unsigned BOUNDARY_VALUES [11] = '{1, 9, 10, 99, 100, 127, 199, 200, 249,
                                                     250, 255};
   localparam int unsigned IDLE_PLAN  [PHASE_COUNT] = '{0, 80, 0, 35};
   localparam int unsigned STALL_PLAN [PHASE_COUNT] = '{0, 0, 80, 35};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_code;
   logic       req_is_last;
   logic       req_no_char;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_usable;

   // Scan model state
   logic [7:0] grp_value;
   logic [1:0] dots_taken;
   logic       grp_has_digit;
   logic       nonzero_seen;
   logic [7:0] lead_group;
   logic       scan_failed;

   logic        usable_q [$];
   logic [7:0]  text_q [$];
   logic        usable_wanted;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned items_sent;
   int unsigned error_count;
   int unsigned cycle_count;

   ipv4_dotted_quad_checker DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .req_no_char   (req_no_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_usable    (rsp_usable)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Return the scan model to its reset state
   function automatic void clear_scan();
      grp_value     = '0;
      dots_taken    = '0;
      grp_has_digit = 1'b0;
      nonzero_seen  = 1'b0;
      lead_group    = '0;
      scan_failed   = 1'b0;
   endfunction

   // Take one character into the scan model
   function automatic void scan_char(input logic [7:0] ch);
      int unsigned next_value;
      if (scan_failed)
         return;
      if (ch == ipv4dq_pkg::DOT_CHAR) begin
         if (!grp_has_digit || dots_taken == ipv4dq_pkg::LAST_DOT) begin
            scan_failed = 1'b1;
         end else begin
            if (dots_taken == 2'd0)
               lead_group = grp_value;
            if (grp_value != 8'd0)
               nonzero_seen = 1'b1;
            dots_taken    = dots_taken + 2'd1;
            grp_value     = '0;
            grp_has_digit = 1'b0;
         end
      end else if (ch >= ipv4dq_pkg::ZERO_CHAR && ch <= ipv4dq_pkg::NINE_CHAR) begin
         next_value    = grp_value * ipv4dq_pkg::RADIX + (ch - ipv4dq_pkg::ZERO_CHAR);
         grp_has_digit = 1'b1;
         if (next_value > ipv4dq_pkg::GROUP_MAX)
            scan_failed = 1'b1;
         else
            grp_value = next_value[7:0];
      end else begin
         scan_failed = 1'b1;
      end
   endfunction

   // Advance the model by one beat; the return value matters on a last beat only
   function automatic logic judge_beat(input logic [7:0] ch, input logic last,
                                       input logic empty);
      logic verdict;
      if (!empty)
         scan_char(ch);
      verdict = !scan_failed && grp_has_digit && dots_taken == ipv4dq_pkg::LAST_DOT &&
                (nonzero_seen || grp_value != 8'd0) &&
                lead_group != ipv4dq_pkg::LOOPBACK_GROUP;
      if (last)
         clear_scan();
      return verdict;
   endfunction

   // Drive one beat, hold it until accepted, then record its expected result
   task automatic deliver(input logic [7:0] ch, input logic last, input logic empty,
                          input logic typed, input logic typed_usable);
      logic predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_is_last   <= last;
      req_no_char   <= empty;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = judge_beat(ch, last, empty);
      if (last)
         usable_q.push_back(typed ? typed_usable : predicted);
      if (last || !empty)
         items_sent++;
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (usable_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic int unsigned pick_group_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45)
         return $urandom_range(255);
      if (sel < 65)
         return 0;
      if (sel < 90)
         return BOUNDARY_VALUES[$urandom_range(10)];
      return $urandom_range(9);
   endfunction

   function automatic void append_group(input int unsigned value, input int unsigned pad);
      string digits;
      digits = $sformatf("%0d", value);
      repeat (pad)
         text_q.push_back(ipv4dq_pkg::ZERO_CHAR);
      for (int i = 0; i < digits.len(); i++)
         text_q.push_back(digits[i]);
   endfunction

   // Build one address text: mostly four groups, some broken on purpose
   function automatic void build_text();
      int unsigned shape;
      int unsigned groups;
      int unsigned value;
      int unsigned pad;
      int unsigned bad_group;
      int unsigned spot;
      text_q.delete();
      shape = $urandom_range(99);
      if (shape >= 97) begin
         // short noise text from digits, dots and any byte
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(2))
               0: text_q.push_back(ipv4dq_pkg::ZERO_CHAR + 8'($urandom_range(9)));
               1: text_q.push_back(ipv4dq_pkg::DOT_CHAR);
               default: text_q.push_back(8'($urandom_range(255)));
            endcase
         end
         return;
      end
      groups = 4;
      if (shape >= 70 && shape < 80) begin
         groups = $urandom_range(5);
         if (groups >= 4)
            groups++;
      end
      bad_group = $urandom_range(3);
      for (int g = 0; g < groups; g++) begin
         if (g != 0)
            text_q.push_back(ipv4dq_pkg::DOT_CHAR);
         value = pick_group_value();
         if (g == 0 && $urandom_range(99) < 10)
            value = ipv4dq_pkg::LOOPBACK_GROUP;
         if (shape < 6)
            value = 0;
         if (shape >= 80 && shape < 88 && g == bad_group)
            value = $urandom_range(1) ? $urandom_range(256, 999) : $urandom_range(1000, 9999);
         pad = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
         append_group(value, pad);
      end
      spot = $urandom_range(text_q.size());
      if (shape >= 88 && shape < 94) begin
         // stray dot: empty group, leading or trailing dot, or one dot too many
         text_q.insert(spot, ipv4dq_pkg::DOT_CHAR);
      end else if (shape >= 94) begin
         // stray byte of any value, inserted or replacing one
         if (spot < text_q.size() && $urandom_range(1))
            text_q[spot] = 8'($urandom_range(255));
         else
            text_q.insert(spot, 8'($urandom_range(255)));
      end
   endfunction

   // Send the text, sprinkling ignored beats, and end it one of two ways
   task automatic send_text();
      bit tail_on_char;
      int unsigned count;
      count        = text_q.size();
      tail_on_char = (count != 0) && ($urandom_range(1) == 1);
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(99) < 6)
            deliver(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0);
         deliver(text_q[k], tail_on_char && k == count - 1, 1'b0, 1'b0, 1'b0);
      end
      if (!tail_on_char)
         deliver(8'($urandom_range(255)), 1'b1, 1'b1, 1'b0, 1'b0);
   endtask

   // Receive results: check each accepted beat and pick the next stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (usable_q.size() == 0) begin
               $error("result with none expected: usable actual %0b", rsp_usable);
               error_count++;
            end else begin
               usable_wanted = usable_q.pop_front();
               if (rsp_usable !== usable_wanted) begin
                  $error("usable: expected %0b, actual %0b", usable_wanted, rsp_usable);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** ipv4_dotted_quad_checker: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned phase_goal;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_code <= '0;
      req_is_last   <= 1'b0;
      req_no_char   <= 1'b0;
      idle_pct       = 0;
      stall_pct      = 0;
      items_sent     = 0;
      error_count    = 0;
      cycle_count    = 0;
      clear_scan();
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (int unsigned r = 0; r < DIRECTED_COUNT; r++)
         deliver(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].empty,
                 DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].usable);
      drain();

      // Random addresses, one idle and stall mix per phase
      phase_goal = items_sent;
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         idle_pct   = IDLE_PLAN[p];
         stall_pct  = STALL_PLAN[p];
         phase_goal = phase_goal + RANDOM_ITEMS / PHASE_COUNT;
         while (items_sent < phase_goal) begin
            build_text();
            send_text();
         end
         drain();
      end

      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (error_count == 0)
         $display("** ipv4_dotted_quad_checker: PASSED **");
      else
         $display("** ipv4_dotted_quad_checker: FAILED **");
      $finish;
   end

endmodule

[files.f]
sv/ipv4dq_pkg.sv
sv/ipv4dq_step.sv
sv/ipv4_dotted_quad_checker.sv
tb/ipv4_dotted_quad_checker_test.sv
